>>> hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/lfu_pkg.sv
package lfu_pkg;
   localparam int unsigned KEY_BITS = 32;
   localparam int unsigned VAL_BITS = 32;
   localparam int unsigned CAP_BITS = 5;
   localparam logic        FUNC_GET = 1'b0;
   localparam logic        FUNC_PUT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_RESP
   } state_type;
endpackage

>>> hdl/lfu_ram.sv
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> hdl/lfu_cache_policy.sv
// LFU cache policy engine: a key-value store of ENTRIES entries with
// least-frequently-used replacement, ties among the lowest use count going to
// the least recently used entry. Each request transfer (func 0 get, 1 put)
// yields one response transfer: found says whether the key was present, and
// read_value carries the stored value on a get hit and zero otherwise.
// Key, value, use count and recency rank of every entry live in one
// synchronous RAM with one read port; the engine works one request at a time.
// A request goes through the steps in order: the request is accepted, one
// pass over the RAM finds the hit, the victim and the first free slot, one
// read-modify-write pass rewrites ranks, counts and the written entry, then
// the response is offered until it is taken. The response register frees
// the request side once the response has been taken.
module lfu_cache_policy
   import lfu_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,   // capacity_limit
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,     // key[31:0], value[63:32]
   input  logic        req_tuser,     // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata      // found[0], read_value[32:1], zero fill
);
   localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS  = $clog2(ENTRIES + 1);
   localparam int WORD_BITS = KEY_BITS + VAL_BITS + COUNT_BITS + IDX_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VAL_BITS-1:0]   value;
      logic [COUNT_BITS-1:0] count;
      logic [IDX_BITS-1:0]   rank;
   } word_type;

   state_type state_ff, state_in;

   logic [CAP_BITS-1:0]   cap_ff;
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [CNT_BITS-1:0]   occ_ff, occ_in;
   logic [IDX_BITS:0]     idx_ff, idx_in;      // pass position, wide enough for ENTRIES
   logic                  rd_lag_ff, rd_lag_in; // a read is in flight
   logic [IDX_BITS-1:0]   lag_idx_ff, lag_idx_in;

   logic                  func_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VAL_BITS-1:0]   val_ff;

   logic                  hit_ff, hit_in;
   logic [IDX_BITS-1:0]   hit_idx_ff, hit_idx_in;
   logic [IDX_BITS-1:0]   hit_rank_ff, hit_rank_in;
   logic                  vic_ok_ff, vic_ok_in;
   logic [IDX_BITS-1:0]   vic_idx_ff, vic_idx_in;
   logic [COUNT_BITS-1:0] vic_cnt_ff, vic_cnt_in;
   logic [IDX_BITS-1:0]   vic_rank_ff, vic_rank_in;
   logic                  free_ok_ff, free_ok_in;
   logic [IDX_BITS-1:0]   free_idx_ff, free_idx_in;
   logic [VAL_BITS-1:0]   rv_ff, rv_in;

   logic                  we;
   logic [IDX_BITS-1:0]   wa, ra;
   word_type              wd, rd;

   logic [CNT_BITS-1:0]   cap_eff;
   logic                  do_insert, do_evict, do_touch, doing;
   logic [IDX_BITS-1:0]   ins_idx, lag_i;
   logic [ENTRIES-1:0]    valid_mid;

   lfu_ram #(.WIDTH(WORD_BITS), .DEPTH(1 << IDX_BITS)) u_ram (
      .clock  (clock),
      .wr_en  (we),
      .wr_addr(wa),
      .wr_data(wd),
      .rd_addr(ra),
      .rd_data(rd)
   );

   // clamp capacity to ENTRIES
   always_comb begin
      if (32'(cap_ff) > 32'(ENTRIES)) begin
         cap_eff = CNT_BITS'(ENTRIES);
      end else begin
         cap_eff = CNT_BITS'(cap_ff);
      end
   end

   // decisions valid after the scan pass
   always_comb begin
      doing     = (func_ff == FUNC_GET) || (cap_eff != '0);
      do_touch  = hit_ff && doing;
      do_evict  = (func_ff == FUNC_PUT) && (cap_eff != '0) && !hit_ff
                  && (32'(occ_ff) >= 32'(cap_eff)) && vic_ok_ff;
      do_insert = (func_ff == FUNC_PUT) && (cap_eff != '0) && !hit_ff
                  && (free_ok_ff || do_evict);
      ins_idx   = free_ok_ff ? free_idx_ff : vic_idx_ff;
      valid_mid = valid_ff;
      if (do_evict) begin
         valid_mid[vic_idx_ff] = 1'b0;
      end
      if (do_insert && !free_ok_ff) begin
         ins_idx = vic_idx_ff;
      end
      // the new key takes the lowest free slot after the eviction, so the
      // victim slot wins when it lies below the first free one
      if (do_insert && do_evict && free_ok_ff && (vic_idx_ff < free_idx_ff)) begin
         ins_idx = vic_idx_ff;
      end
   end

   assign lag_i = lag_idx_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!rd_lag_ff && (32'(idx_ff) >= ENTRIES) && idx_ff != '0) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!rd_lag_ff && (32'(idx_ff) >= ENTRIES) && idx_ff != '0) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic live;
      live        = 1'b0;
      req_tready  = (state_ff == ST_IDLE);
      rsp_tvalid  = (state_ff == ST_RESP);
      rsp_tdata   = {7'd0, rv_ff, hit_ff};
      idx_in      = idx_ff;
      rd_lag_in   = 1'b0;
      lag_idx_in  = lag_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_rank_in = hit_rank_ff;
      vic_ok_in   = vic_ok_ff;
      vic_idx_in  = vic_idx_ff;
      vic_cnt_in  = vic_cnt_ff;
      vic_rank_in = vic_rank_ff;
      free_ok_in  = free_ok_ff;
      free_idx_in = free_idx_ff;
      rv_in       = rv_ff;
      valid_in    = valid_ff;
      occ_in      = occ_ff;
      ra          = idx_ff[IDX_BITS-1:0];
      we          = 1'b0;
      wa          = lag_i;
      wd          = rd;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in     = '0;
            hit_in     = 1'b0;
            vic_ok_in  = 1'b0;
            free_ok_in = 1'b0;
            rv_in      = '0;
         end
         ST_SCAN: begin
            // issue reads, then examine the word that came back
            if (32'(idx_ff) < ENTRIES) begin
               rd_lag_in  = 1'b1;
               lag_idx_in = idx_ff[IDX_BITS-1:0];
               idx_in     = idx_ff + 1'b1;
            end
            if (rd_lag_ff) begin
               live = valid_ff[lag_i];
               if (!live && !free_ok_in) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = lag_i;
               end
               if (live && rd.key == key_ff && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = lag_i;
                  hit_rank_in = rd.rank;
                  rv_in       = (func_ff == FUNC_GET) ? rd.value : '0;
               end
               if (live && (!vic_ok_ff || rd.count < vic_cnt_ff
                      || (rd.count == vic_cnt_ff && rd.rank > vic_rank_ff))) begin
                  vic_ok_in   = 1'b1;
                  vic_idx_in  = lag_i;
                  vic_cnt_in  = rd.count;
                  vic_rank_in = rd.rank;
               end
            end
            if (state_in == ST_UPDATE) begin
               idx_in = '0;
            end
         end
         ST_UPDATE: begin
            if (32'(idx_ff) < ENTRIES) begin
               rd_lag_in  = 1'b1;
               lag_idx_in = idx_ff[IDX_BITS-1:0];
               idx_in     = idx_ff + 1'b1;
            end
            if (rd_lag_ff) begin
               wd = rd;
               we = 1'b0;
               if (do_touch) begin
                  if (lag_i == hit_idx_ff) begin
                     we      = 1'b1;
                     wd.rank = '0;
                     if (rd.count != COUNT_MAX) begin
                        wd.count = rd.count + 1'b1;
                     end
                     if (func_ff == FUNC_PUT) begin
                        wd.value = val_ff;
                     end
                  end else if (valid_ff[lag_i] && rd.rank < hit_rank_ff) begin
                     we      = 1'b1;
                     wd.rank = rd.rank + 1'b1;
                  end
               end else if (do_insert) begin
                  if (lag_i == ins_idx) begin
                     we       = 1'b1;
                     wd.key   = key_ff;
                     wd.value = val_ff;
                     wd.count = COUNT_BITS'(1);
                     wd.rank  = '0;
                  end else if (valid_mid[lag_i]) begin
                     we      = 1'b1;
                     wd.rank = rd.rank + 1'b1;
                     if (do_evict && rd.rank > vic_rank_ff) begin
                        wd.rank = rd.rank;
                     end
                  end
               end
            end
            if (state_in == ST_RESP) begin
               valid_in = valid_mid;
               if (do_insert) begin
                  valid_in[ins_idx] = 1'b1;
                  if (!do_evict) begin
                     occ_in = occ_ff + 1'b1;
                  end
               end
            end
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cap_ff    <= CAP_BITS'(16);
         valid_ff  <= '0;
         occ_ff    <= '0;
         rd_lag_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         occ_ff    <= occ_in;
         rd_lag_ff <= rd_lag_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      lag_idx_ff  <= lag_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_rank_ff <= hit_rank_in;
      vic_ok_ff   <= vic_ok_in;
      vic_idx_ff  <= vic_idx_in;
      vic_cnt_ff  <= vic_cnt_in;
      vic_rank_ff <= vic_rank_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      rv_ff       <= rv_in;
      if (req_tvalid && req_tready) begin
         func_ff <= req_tuser;
         key_ff  <= req_tdata[31:0];
         val_ff  <= req_tdata[63:32];
      end
   end
endmodule

>>> hdl/lfu_checker.sv
`include "assert_macros.svh"
module lfu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "response dropped")
   `ASSERT_IMP(a_excl, clock, reset, rsp_tvalid, !req_tready, "request taken with response pending")
   `ASSERT_IMP(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[32:1] == 32'd0, "miss carries data")
   `ASSERT_NEXT(a_no_early, clock, reset, req_tvalid && req_tready, !rsp_tvalid, "response too early")
endmodule

bind lfu_cache_policy lfu_checker u_lfu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
